### rtl/page_buffer_pool_directory_defines.svh
// ----------------------------------------------------------------------------
// page buffer pool directory assertion macros
// shared property forms for the directory checks
// ----------------------------------------------------------------------------
`ifndef PAGE_BUFFER_POOL_DIRECTORY_DEFINES_SVH
`define PAGE_BUFFER_POOL_DIRECTORY_DEFINES_SVH

// same-cycle implication
`define PBPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pbpd_pkg.sv
// ----------------------------------------------------------------------------
// pbpd_pkg
// shared constants and types of the page buffer pool directory
// ----------------------------------------------------------------------------
package pbpd_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int TAG_W     = 56;
  localparam int PIN_W     = 16;

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_READ_NEW = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_DIRTY   = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;
  localparam logic [2:0] OP_INVAL   = 3'd5;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_NO_SLOT = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_BAD_TAG = 3'd4;

  typedef enum logic [2:0] {
    TGT_KEEP = 3'd0,
    TGT_HIT  = 3'd1,
    TGT_POP  = 3'd2,
    TGT_PTR  = 3'd3,
    TGT_NEXT = 3'd4
  } tgt_sel_e;

  typedef struct packed {
    logic       ld_in;
    logic       set_status;
    logic [2:0] status;
    logic       set_slot;
    tgt_sel_e   tgt_sel;
    logic       srch_start;
    logic       srch_step;
    logic       tag_rd_tgt;
    logic       pin_inc;
    logic       pin_dec;
    logic       set_dirty;
    logic       clr_dirty;
    logic       inval;
    logic       push;
    logic       pop;
    logic       alloc;
    logic       adv_ptr;
    logic       scan_start;
    logic       scan_step;
    logic       wb_in;
    logic       wb_mem;
    logic       install;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       db_zero;
    logic       match;
    logic       srch_last;
    logic       tgt_tag_vld;
    logic       tgt_pin_nz;
    logic       tgt_dirty;
    logic       tgt_alloc;
    logic       fc_nz;
    logic       fc_full;
    logic       pop_ok;
    logic       scan_last;
    logic       flush_first;
    logic       out_free;
  } sts_t;

endpackage

### rtl/page_buffer_pool_directory.sv
// a linear search from slot 0 finds hits; a miss pops the free stack, skipping stale entries,
// then takes the pointer slot if it was never allocated, else scans on for an unpinned victim;
// output stalls delay every result
// one word in flight: a new word can be taken in the cycle after the previous result is loaded
// reset: directory empty, pins and dirty bits clear, pointer 0, slots_in_use 64
// ----------------------------------------------------------------------------
// page_buffer_pool_directory
// pinned page buffer directory with free stack and round-robin replacement
// ----------------------------------------------------------------------------
`include "page_buffer_pool_directory_defines.svh"

module page_buffer_pool_directory (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  db_id_i,
  input  logic [15:0] file_id_i,
  input  logic [31:0] block_id_i,
  input  logic [5:0]  slot_i,
  input  logic        flush_first_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_out_o,
  output logic        read_needed_o,
  output logic        writeback_needed_o,
  output logic [7:0]  wb_db_id_o,
  output logic [15:0] wb_file_id_o,
  output logic [31:0] wb_block_id_o
);
  import pbpd_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_we;
  logic [6:0] slots_in_use;

  // single register, written at address 0 and read back at every address
  assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
  assign pready = 1'b1;
  assign prdata = {25'd0, slots_in_use};

  pbpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pbpd_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (opcode_i),
    .db_id_i            (db_id_i),
    .file_id_i          (file_id_i),
    .block_id_i         (block_id_i),
    .slot_i             (slot_i),
    .flush_first_i      (flush_first_i),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (pwdata[6:0]),
    .slots_in_use_o     (slots_in_use),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .slot_out_o         (slot_out_o),
    .read_needed_o      (read_needed_o),
    .writeback_needed_o (writeback_needed_o),
    .wb_db_id_o         (wb_db_id_o),
    .wb_file_id_o       (wb_file_id_o),
    .wb_block_id_o      (wb_block_id_o)
  );

  `PBPD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `PBPD_ASSERT_NOW(a_read_only_new, out_valid_o && read_needed_o, status_o == ST_NEW, "read without new slot")
  `PBPD_ASSERT_NOW(a_wb_tag_valid, out_valid_o && writeback_needed_o, wb_db_id_o != 8'd0, "writeback of invalid tag")

endmodule

### rtl/pbpd_datapath.sv
// ----------------------------------------------------------------------------
// pbpd_datapath
// slot directory stores, free stack, pointers and result registers
// ----------------------------------------------------------------------------
module pbpd_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pbpd_pkg::cmd_t         cmd_i,
  output pbpd_pkg::sts_t         sts_o,
  input  logic [2:0]             opcode_i,
  input  logic [7:0]             db_id_i,
  input  logic [15:0]            file_id_i,
  input  logic [31:0]            block_id_i,
  input  logic [5:0]             slot_i,
  input  logic                   flush_first_i,
  input  logic                   cfg_we_i,
  input  logic [6:0]             cfg_wdata_i,
  output logic [6:0]             slots_in_use_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [2:0]             status_o,
  output logic [5:0]             slot_out_o,
  output logic                   read_needed_o,
  output logic                   writeback_needed_o,
  output logic [7:0]             wb_db_id_o,
  output logic [15:0]            wb_file_id_o,
  output logic [31:0]            wb_block_id_o
);
  import pbpd_pkg::*;

  logic [TAG_W-1:0]     tag_mem [NUM_SLOTS];
  logic [PIN_W-1:0]     pin_mem [NUM_SLOTS];
  logic [SLOT_W-1:0]    stack_mem [NUM_SLOTS];

  logic [TAG_W-1:0]     tag_rd_q;
  logic [PIN_W-1:0]     pin_rd_q;
  logic [SLOT_W-1:0]    stack_rd_q;

  logic [NUM_SLOTS-1:0] tag_vld_q, dirty_q, alloc_q, pin_nz_q;
  logic [2:0]           op_q;
  logic [TAG_W-1:0]     tag_q;
  logic                 ff_q;
  logic [SLOT_W-1:0]    tgt_q, tgt_d;
  logic [SLOT_W-1:0]    srch_cnt_q, cmp_idx_q;
  logic                 cmp_vld_q;
  logic [CNT_W-1:0]     scan_cnt_q;
  logic [SLOT_W-1:0]    next_q;
  logic [CNT_W-1:0]     fc_q;
  logic [6:0]           slots_q;

  logic [2:0]           res_status_q;
  logic [SLOT_W-1:0]    res_slot_q;
  logic                 res_rd_q, res_wb_q;
  logic [TAG_W-1:0]     res_wb_tag_q;

  logic                 out_valid_q;
  logic [2:0]           out_status_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic                 out_rd_q, out_wb_q;
  logic [TAG_W-1:0]     out_wb_tag_q;

  logic [CNT_W-1:0]     n_eff, tgt_inc, fc_m1;
  logic [SLOT_W-1:0]    ptr_idx, tgt_adv, tag_raddr;
  logic [PIN_W-1:0]     pin_cur, pin_new;

  always_comb begin
    if (slots_q == 7'd0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(slots_q) > CNT_W'(NUM_SLOTS) || slots_q > 7'(NUM_SLOTS)) begin
      n_eff = CNT_W'(NUM_SLOTS);
    end else begin
      n_eff = CNT_W'(slots_q);
    end
  end

  assign ptr_idx   = ({1'b0, next_q} >= n_eff) ? '0 : next_q;
  assign tgt_inc   = {1'b0, tgt_q} + CNT_W'(1);
  assign tgt_adv   = (tgt_inc == n_eff) ? '0 : tgt_inc[SLOT_W-1:0];
  assign fc_m1     = fc_q - CNT_W'(1);
  assign tag_raddr = cmd_i.tag_rd_tgt ? tgt_q : srch_cnt_q;
  assign pin_cur   = pin_nz_q[tgt_q] ? pin_rd_q : '0;

  always_comb begin
    pin_new = pin_cur;
    if (cmd_i.pin_inc && pin_cur != {PIN_W{1'b1}}) begin
      pin_new = pin_cur + PIN_W'(1);
    end else if (cmd_i.pin_dec && pin_cur != '0) begin
      pin_new = pin_cur - PIN_W'(1);
    end
  end

  always_comb begin
    case (cmd_i.tgt_sel)
      TGT_KEEP: tgt_d = tgt_q;
      TGT_HIT:  tgt_d = cmp_idx_q;
      TGT_POP:  tgt_d = stack_rd_q;
      TGT_PTR:  tgt_d = ptr_idx;
      TGT_NEXT: tgt_d = tgt_adv;
      default:  tgt_d = tgt_q;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    tag_rd_q   <= tag_mem[tag_raddr];
    pin_rd_q   <= pin_mem[tgt_q];
    stack_rd_q <= stack_mem[fc_m1[SLOT_W-1:0]];
    if (cmd_i.install) begin
      tag_mem[tgt_q] <= tag_q;
      pin_mem[tgt_q] <= PIN_W'(1);
    end
    if (cmd_i.pin_inc || cmd_i.pin_dec) begin
      pin_mem[tgt_q] <= pin_new;
    end
    if (cmd_i.push) begin
      stack_mem[fc_q[SLOT_W-1:0]] <= tgt_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q  <= opcode_i;
      tag_q <= {db_id_i, file_id_i, block_id_i};
      ff_q  <= flush_first_i;
    end
    if (cmd_i.srch_step) begin
      cmp_idx_q <= srch_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q    <= '0;
      dirty_q      <= '0;
      alloc_q      <= '0;
      pin_nz_q     <= '0;
      tgt_q        <= '0;
      srch_cnt_q   <= '0;
      cmp_vld_q    <= 1'b0;
      scan_cnt_q   <= '0;
      next_q       <= '0;
      fc_q         <= '0;
      slots_q      <= 7'(NUM_SLOTS);
      res_status_q <= ST_DONE;
      res_slot_q   <= '0;
      res_rd_q     <= 1'b0;
      res_wb_q     <= 1'b0;
      res_wb_tag_q <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_DONE;
      out_slot_q   <= '0;
      out_rd_q     <= 1'b0;
      out_wb_q     <= 1'b0;
      out_wb_tag_q <= '0;
    end else begin
      if (cfg_we_i) begin
        slots_q <= cfg_wdata_i;
      end
      if (cmd_i.ld_in) begin
        tgt_q        <= slot_i;
        res_status_q <= ST_DONE;
        res_slot_q   <= '0;
        res_rd_q     <= 1'b0;
        res_wb_q     <= 1'b0;
        res_wb_tag_q <= '0;
      end else begin
        tgt_q <= tgt_d;
      end
      if (cmd_i.srch_start) begin
        srch_cnt_q <= '0;
        cmp_vld_q  <= 1'b0;
      end else if (cmd_i.srch_step) begin
        srch_cnt_q <= srch_cnt_q + SLOT_W'(1);
        cmp_vld_q  <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_cnt_q <= scan_cnt_q + CNT_W'(1);
      end
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.set_slot) begin
        res_slot_q <= tgt_q;
      end
      if (cmd_i.wb_in) begin
        res_wb_q     <= 1'b1;
        res_wb_tag_q <= tag_q;
      end else if (cmd_i.wb_mem) begin
        res_wb_q     <= 1'b1;
        res_wb_tag_q <= tag_rd_q;
      end
      if (cmd_i.set_dirty) begin
        dirty_q[tgt_q] <= 1'b1;
      end
      if (cmd_i.clr_dirty) begin
        dirty_q[tgt_q] <= 1'b0;
      end
      if (cmd_i.inval) begin
        tag_vld_q[tgt_q] <= 1'b0;
        dirty_q[tgt_q]   <= 1'b0;
      end
      if (cmd_i.pin_inc || cmd_i.pin_dec) begin
        pin_nz_q[tgt_q] <= (pin_new != '0);
      end
      if (cmd_i.push) begin
        fc_q <= fc_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        fc_q <= fc_m1;
      end
      if (cmd_i.alloc) begin
        alloc_q[tgt_q] <= 1'b1;
      end
      if (cmd_i.adv_ptr) begin
        next_q <= tgt_adv;
      end
      if (cmd_i.install) begin
        tag_vld_q[tgt_q] <= 1'b1;
        dirty_q[tgt_q]   <= 1'b0;
        pin_nz_q[tgt_q]  <= 1'b1;
        res_status_q     <= ST_NEW;
        res_slot_q       <= tgt_q;
        res_rd_q         <= (op_q == OP_READ);
      end
      if (cmd_i.out_load) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_slot_q   <= res_slot_q;
        out_rd_q     <= res_rd_q;
        out_wb_q     <= res_wb_q;
        out_wb_tag_q <= res_wb_tag_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.op          = op_q;
    sts_o.db_zero     = (tag_q[TAG_W-1 -: 8] == 8'd0);
    sts_o.match       = cmp_vld_q && tag_vld_q[cmp_idx_q] && (tag_rd_q == tag_q);
    sts_o.srch_last   = cmp_vld_q && (cmp_idx_q == SLOT_W'(NUM_SLOTS - 1));
    sts_o.tgt_tag_vld = tag_vld_q[tgt_q];
    sts_o.tgt_pin_nz  = pin_nz_q[tgt_q];
    sts_o.tgt_dirty   = dirty_q[tgt_q];
    sts_o.tgt_alloc   = alloc_q[tgt_q];
    sts_o.fc_nz       = (fc_q != '0);
    sts_o.fc_full     = (fc_q == CNT_W'(NUM_SLOTS));
    sts_o.pop_ok      = !tag_vld_q[stack_rd_q] && !pin_nz_q[stack_rd_q];
    sts_o.scan_last   = (scan_cnt_q == n_eff - CNT_W'(1));
    sts_o.flush_first = ff_q;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign slots_in_use_o     = slots_q;
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign slot_out_o         = out_slot_q;
  assign read_needed_o      = out_rd_q;
  assign writeback_needed_o = out_wb_q;
  assign wb_db_id_o         = out_wb_tag_q[55:48];
  assign wb_file_id_o       = out_wb_tag_q[47:32];
  assign wb_block_id_o      = out_wb_tag_q[31:0];

endmodule

### rtl/pbpd_ctrl.sv
// ----------------------------------------------------------------------------
// pbpd_ctrl
// request sequencer: lookup, victim choice and result hand-off
// ----------------------------------------------------------------------------
module pbpd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pbpd_pkg::sts_t sts_i,
  output pbpd_pkg::cmd_t cmd_o
);
  import pbpd_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DISP    = 13'b0000000000010,
    S_SRCH    = 13'b0000000000100,
    S_HIT     = 13'b0000000001000,
    S_PINRD   = 13'b0000000010000,
    S_PINUPD  = 13'b0000000100000,
    S_MISS    = 13'b0000001000000,
    S_POPCHK  = 13'b0000010000000,
    S_PTR     = 13'b0000100000000,
    S_SCAN    = 13'b0001000000000,
    S_WBRD    = 13'b0010000000000,
    S_INSTALL = 13'b0100000000000,
    S_FIN     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   needs_tag, is_read;

  assign is_read   = (sts_i.op == OP_READ) || (sts_i.op == OP_READ_NEW);
  assign needs_tag = is_read || (sts_i.op == OP_FLUSH) || (sts_i.op == OP_INVAL);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        if (needs_tag && sts_i.db_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_BAD_TAG;
          state_d          = S_FIN;
        end else if (sts_i.op == OP_RELEASE) begin
          cmd_o.set_slot = 1'b1;
          state_d        = sts_i.tgt_pin_nz ? S_PINRD : S_FIN;
        end else if (sts_i.op == OP_DIRTY) begin
          if (sts_i.tgt_tag_vld) begin
            cmd_o.set_dirty = 1'b1;
            cmd_o.set_slot  = 1'b1;
          end else begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_ABSENT;
          end
          state_d = S_FIN;
        end else if (needs_tag) begin
          cmd_o.srch_start = 1'b1;
          state_d          = S_SRCH;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SRCH: begin
        if (sts_i.match) begin
          cmd_o.tgt_sel = TGT_HIT;
          state_d       = S_HIT;
        end else if (sts_i.srch_last) begin
          if (is_read) begin
            state_d = S_MISS;
          end else begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_ABSENT;
            state_d          = S_FIN;
          end
        end else begin
          cmd_o.srch_step = 1'b1;
        end
      end
      S_HIT: begin
        cmd_o.set_slot = 1'b1;
        if (is_read) begin
          state_d = S_PINRD;
        end else if (sts_i.op == OP_FLUSH) begin
          if (sts_i.tgt_dirty) begin
            cmd_o.wb_in     = 1'b1;
            cmd_o.clr_dirty = 1'b1;
          end
          state_d = S_FIN;
        end else begin
          if (sts_i.tgt_pin_nz) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_NO_SLOT;
          end else begin
            cmd_o.wb_in = sts_i.flush_first && sts_i.tgt_dirty;
            cmd_o.inval = 1'b1;
            cmd_o.push  = !sts_i.fc_full;
          end
          state_d = S_FIN;
        end
      end
      S_PINRD: begin
        state_d = S_PINUPD;
      end
      S_PINUPD: begin
        if (sts_i.op == OP_RELEASE) begin
          cmd_o.pin_dec = 1'b1;
        end else begin
          cmd_o.pin_inc = 1'b1;
        end
        state_d = S_FIN;
      end
      S_MISS: begin
        if (sts_i.fc_nz) begin
          cmd_o.pop = 1'b1;
          state_d   = S_POPCHK;
        end else begin
          cmd_o.tgt_sel = TGT_PTR;
          state_d       = S_PTR;
        end
      end
      S_POPCHK: begin
        if (sts_i.pop_ok) begin
          cmd_o.tgt_sel = TGT_POP;
          state_d       = S_INSTALL;
        end else begin
          state_d = S_MISS;
        end
      end
      S_PTR: begin
        if (!sts_i.tgt_alloc) begin
          cmd_o.alloc   = 1'b1;
          cmd_o.adv_ptr = 1'b1;
          state_d       = S_INSTALL;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.tgt_pin_nz) begin
          if (sts_i.tgt_tag_vld && sts_i.tgt_dirty) begin
            cmd_o.tag_rd_tgt = 1'b1;
            state_d          = S_WBRD;
          end else begin
            cmd_o.adv_ptr = 1'b1;
            state_d       = S_INSTALL;
          end
        end else if (sts_i.scan_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NO_SLOT;
          state_d          = S_FIN;
        end else begin
          cmd_o.scan_step = 1'b1;
          cmd_o.tgt_sel   = TGT_NEXT;
        end
      end
      S_WBRD: begin
        cmd_o.wb_mem  = 1'b1;
        cmd_o.adv_ptr = 1'b1;
        state_d       = S_INSTALL;
      end
      S_INSTALL: begin
        cmd_o.install = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
